>>> sv/bmi_pkg.sv
// Package for the bus mouse interface: command codes, item and result
// structs, bus constants and the saturating add and port A helpers.
// No dependencies.
package bmi_pkg;

  typedef enum logic [2:0] {
    CMD_MOTION   = 3'd0,
    CMD_CTRL_WR  = 3'd1,
    CMD_BUS_WR   = 3'd2,
    CMD_BUS_RD   = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  localparam logic [15:0] RATE_ADDR      = 16'hBFDB;
  localparam logic [7:0]  RATE_RSVD_MASK = 8'hFC;
  localparam logic [7:0]  BUS_FLOAT      = 8'hFF;
  localparam int unsigned CTRL_IRQ_OFF   = 4;
  localparam int unsigned CTRL_LATCH     = 7;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [2:0]         buttons;
    logic [15:0]        bus_addr;
    logic [7:0]         write_data;
    logic [7:0]         write_mask;
  } item_t;

  typedef struct packed {
    logic [7:0] port_a;
    logic       port_a_new;
    logic       irq;
    logic [7:0] read_data;
  } result_t;

  // Clamp delta to +-32, add to signed 8-bit accumulator, saturate.
  function automatic logic [7:0] sat_add(logic [7:0] acc, logic signed [15:0] d);
    logic signed [6:0] dc;
    logic signed [8:0] s;
    if (d > 16'sd32) begin
      dc = 7'sd32;
    end else if (d < -16'sd32) begin
      dc = -7'sd32;
    end else begin
      dc = d[6:0];
    end
    s = $signed({acc[7], acc}) + $signed({{2{dc[6]}}, dc});
    if (s > 9'sd127) begin
      return 8'h7F;
    end else if (s < -9'sd128) begin
      return 8'h80;
    end
    return s[7:0];
  endfunction

  function automatic logic [7:0] port_value(logic [2:0] buttons, logic [7:0] ctrl,
                                            logic [7:0] ax, logic [7:0] ay,
                                            logic [7:0] lx, logic [7:0] ly);
    logic [7:0] src;
    logic [3:0] nib;
    case (ctrl[7:6])
      2'd0:    src = ax;
      2'd1:    src = ay;
      2'd2:    src = lx;
      default: src = ly;
    endcase
    nib = ctrl[5] ? src[7:4] : src[3:0];
    return {~buttons[0], ~buttons[2], ~buttons[1], 1'b0, nib};
  endfunction

endpackage

>>> sv/bmi_core.sv
// Mouse state registers (accumulators, latches, control, rate, tick count)
// and the combinational update for one item. Uses bmi_pkg.
module bmi_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bmi_pkg::item_t   item_i,
  output bmi_pkg::result_t result_o
);

  logic [7:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [7:0] latch_x_q, latch_x_d, latch_y_q, latch_y_d;
  logic [7:0] control_q, control_d;
  logic [1:0] rate_sel_q, rate_sel_d, active_rate_q, active_rate_d;
  logic [2:0] tick_cnt_q, tick_cnt_d;

  logic [2:0] tick_inc;
  logic       tick_wrap;

  assign tick_inc  = tick_cnt_q + 3'd1;
  assign tick_wrap = (tick_inc == 3'd0) ||
                     ({1'b0, tick_inc} >= (4'd1 << active_rate_q));

  always_comb begin
    acc_x_d       = acc_x_q;
    acc_y_d       = acc_y_q;
    latch_x_d     = latch_x_q;
    latch_y_d     = latch_y_q;
    control_d     = control_q;
    rate_sel_d    = rate_sel_q;
    active_rate_d = active_rate_q;
    tick_cnt_d    = tick_cnt_q;
    result_o      = '0;
    unique case (bmi_pkg::cmd_e'(item_i.cmd))
      bmi_pkg::CMD_MOTION: begin
        acc_x_d = bmi_pkg::sat_add(acc_x_q, item_i.delta_x);
        acc_y_d = bmi_pkg::sat_add(acc_y_q, item_i.delta_y);
        result_o.port_a_new = 1'b1;
      end
      bmi_pkg::CMD_CTRL_WR: begin
        if (!control_q[bmi_pkg::CTRL_LATCH] && item_i.write_data[bmi_pkg::CTRL_LATCH]) begin
          latch_x_d = acc_x_q;
          latch_y_d = acc_y_q;
          acc_x_d   = '0;
          acc_y_d   = '0;
        end
        control_d = item_i.write_data & item_i.write_mask;
        result_o.port_a_new = 1'b1;
      end
      bmi_pkg::CMD_BUS_WR: begin
        if (item_i.bus_addr == bmi_pkg::RATE_ADDR &&
            (item_i.write_data & bmi_pkg::RATE_RSVD_MASK) == 8'h00) begin
          rate_sel_d = item_i.write_data[1:0];
        end
      end
      bmi_pkg::CMD_BUS_RD: begin
        result_o.read_data = (item_i.bus_addr == bmi_pkg::RATE_ADDR) ?
                             {6'd0, rate_sel_q} : bmi_pkg::BUS_FLOAT;
      end
      bmi_pkg::CMD_TICK: begin
        tick_cnt_d = tick_inc;
        if (tick_wrap) begin
          result_o.irq  = !control_q[bmi_pkg::CTRL_IRQ_OFF];
          tick_cnt_d    = '0;
          active_rate_d = rate_sel_q;
        end
      end
      default: begin
      end
    endcase
    if (result_o.port_a_new) begin
      result_o.port_a = bmi_pkg::port_value(item_i.buttons, control_d, acc_x_d,
                                            acc_y_d, latch_x_d, latch_y_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      latch_x_q     <= 8'hFF;
      latch_y_q     <= 8'hFF;
      control_q     <= 8'hFF;
      rate_sel_q    <= '0;
      active_rate_q <= '0;
      tick_cnt_q    <= '0;
    end else if (step_i) begin
      acc_x_q       <= acc_x_d;
      acc_y_q       <= acc_y_d;
      latch_x_q     <= latch_x_d;
      latch_y_q     <= latch_y_d;
      control_q     <= control_d;
      rate_sel_q    <= rate_sel_d;
      active_rate_q <= active_rate_d;
      tick_cnt_q    <= tick_cnt_d;
    end
  end

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, tick_cnt_q} < (4'd1 << active_rate_q))
    else $error("tick count past interrupt period");

  a_latch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == bmi_pkg::CMD_CTRL_WR && !control_q[bmi_pkg::CTRL_LATCH]
    && item_i.write_data[bmi_pkg::CTRL_LATCH] |=> acc_x_q == 8'h00 && acc_y_q == 8'h00)
    else $error("accumulators not cleared on latch");

endmodule

>>> sv/bus_mouse_interface.sv
// Bus mouse interface top level: input register, state core, result register.
// Uses bmi_pkg and bmi_core.
//
// One item can transfer in every cycle while out_ready_i is high. An accepted
// item waits in the input register until the result register is free. Then the
// state update and the port A computation run in one short combinational pass
// into the result register, and out_valid_o is set as the result is captured.
// While a result waits, one more item can be taken into the input register.
// After that, in_ready_o stays low until the result transfers. Throughput is
// one item per cycle while out_ready_i is high. Every item gives exactly one
// result; unused fields of a result read zero.
module bus_mouse_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  input  logic [2:0]  buttons_i,
  input  logic [15:0] bus_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  write_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  port_a_o,
  output logic        port_a_new_o,
  output logic        irq_o,
  output logic [7:0]  read_data_o
);

  bmi_pkg::item_t   item_q;
  bmi_pkg::result_t res_d, res_q;
  logic             in_valid_q, out_valid_q;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{cmd: cmd_i, delta_x: delta_x_i, delta_y: delta_y_i, buttons: buttons_i,
                  bus_addr: bus_addr_i, write_data: write_data_i,
                  write_mask: write_mask_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  bmi_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_valid_o  = out_valid_q;
  assign port_a_o     = res_q.port_a;
  assign port_a_new_o = res_q.port_a_new;
  assign irq_o        = res_q.irq;
  assign read_data_o  = res_q.read_data;

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result lost after advance");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("input register changed while stalled");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_o |-> !port_a_new_o && port_a_o == 8'h00 && read_data_o == 8'h00)
    else $error("interrupt result carries other fields");

endmodule
